// ----- rtl/rsmt_pkg.sv -----
// ----------------------------------------------------------------------------
// rsmt_pkg
// Shared types and codes for the random-sample multiset table.
// ----------------------------------------------------------------------------
package rsmt_pkg;

    localparam int VALUE_W   = 32;
    localparam int STAMP_W   = 64;
    localparam int RAND_W    = 31;
    localparam int BIT_CNT_W = $clog2(RAND_W);

    // operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    // status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STAMP_W-1:0] stamp;
    } slot_t;

endpackage

// ----- rtl/rsmt_mod.sv -----
// ----------------------------------------------------------------------------
// rsmt_mod
// Bit-serial restoring remainder unit: one dividend bit per cycle.
// ----------------------------------------------------------------------------
module rsmt_mod
    import rsmt_pkg::*;
#(
    parameter int DIV_W = 7
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [RAND_W-1:0] dividend,
    input  logic [DIV_W-1:0]  divisor,
    output logic              done,
    output logic [DIV_W-1:0]  remainder
);

    logic                 run_reg,  run_next;
    logic                 done_reg, done_next;
    logic [BIT_CNT_W-1:0] bit_reg,  bit_next;
    logic [RAND_W-1:0]    quo_reg,  quo_next;
    logic [DIV_W-1:0]     rem_reg,  rem_next;
    logic [DIV_W-1:0]     dsr_reg,  dsr_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;

    assign trial = {rem_reg, quo_reg[RAND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};

    always_comb begin
        run_next  = run_reg;
        done_next = 1'b0;
        bit_next  = bit_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            run_next = 1'b1;
            bit_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end else if (run_reg) begin
            // shift in the next dividend bit, subtract when it fits
            quo_next = {quo_reg[RAND_W-2:0], 1'b0};
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = diff[DIV_W-1:0];
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            bit_next = bit_reg + 1'b1;
            if (bit_reg == BIT_CNT_W'(RAND_W - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
        bit_reg <= bit_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/random_sample_multiset_table_top.sv -----
// ----------------------------------------------------------------------------
// random_sample_multiset_table_top
// Multiset of signed values in a dense slot memory with insert, remove of the
// newest copy, and random sampling.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake        | Beat payload
//  --------+-----------+------------------+-------------------------------------
//  s_      | in        | s_valid/s_ready  | operation, item_value, random_word
//  m_      | out       | m_valid/m_ready  | flag, sampled_value, status
//
//  Insert and remove walk every occupied slot through one memory read port,
//  one slot per cycle, then write; remove may first read the last slot.
//  Sample runs the bit-serial remainder unit and then one slot read.
//  Refused inserts, empty-table samples and unused codes go straight to done.
//  Reset (aresetn low, synchronous) empties the table and zeroes the stamps.
//  s_ready is high only in idle; a finished beat waits in the output register.
//
module random_sample_multiset_table_top
    import rsmt_pkg::*;
#(
    parameter int CAPACITY = 64
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [1:0]                s_operation,
    input  logic signed [VALUE_W-1:0] s_item_value,
    input  logic [RAND_W-1:0]         s_random_word,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_flag,
    output logic signed [VALUE_W-1:0] m_sampled_value,
    output logic [1:0]                m_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INS_WR,
        ST_RD_LAST,
        ST_RM_WR,
        ST_DIV,
        ST_RD_SAMP,
        ST_SAMP_GET,
        ST_DONE
    } state_t;

    // slot memory: value and order stamp side by side
    slot_t slot_mem [CAPACITY];
    slot_t rd_data;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;

    state_t               state_reg,   state_next;
    logic [CNT_W-1:0]     count_reg,   count_next;
    logic [STAMP_W-1:0]   stamp_reg,   stamp_next;
    logic [1:0]           op_reg,      op_next;
    logic [VALUE_W-1:0]   val_reg,     val_next;
    logic [CNT_W-1:0]     issue_reg,   issue_next;
    logic                 pipe_vld_reg, pipe_vld_next;
    logic [IDX_W-1:0]     pipe_idx_reg, pipe_idx_next;
    logic                 hit_reg,     hit_next;
    logic [IDX_W-1:0]     pos_reg,     pos_next;
    logic [STAMP_W-1:0]   best_reg,    best_next;
    logic                 res_flag_reg,    res_flag_next;
    logic [VALUE_W-1:0]   res_sampled_reg, res_sampled_next;
    logic [1:0]           res_status_reg,  res_status_next;
    logic                 m_valid_reg,   m_valid_next;
    logic                 m_flag_reg,    m_flag_next;
    logic [VALUE_W-1:0]   m_sampled_reg, m_sampled_next;
    logic [1:0]           m_status_reg,  m_status_next;

    logic             div_start;
    logic             div_done;
    logic [CNT_W-1:0] div_rem;
    logic [CNT_W-1:0] last_idx;
    logic             slot_match;

    assign last_idx   = count_reg - 1'b1;
    assign slot_match = (rd_data.value == val_reg) &&
                        (!hit_reg || (rd_data.stamp > best_reg));

    rsmt_mod #(
        .DIV_W(CNT_W)
    ) u_mod (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_random_word),
        .divisor  (count_reg),
        .done     (div_done),
        .remainder(div_rem)
    );

    always_comb begin
        state_next       = state_reg;
        count_next       = count_reg;
        stamp_next       = stamp_reg;
        op_next          = op_reg;
        val_next         = val_reg;
        issue_next       = issue_reg;
        pipe_vld_next    = 1'b0;
        pipe_idx_next    = pipe_idx_reg;
        hit_next         = hit_reg;
        pos_next         = pos_reg;
        best_next        = best_reg;
        res_flag_next    = res_flag_reg;
        res_sampled_next = res_sampled_reg;
        res_status_next  = res_status_reg;
        m_valid_next     = m_valid_reg;
        m_flag_next      = m_flag_reg;
        m_sampled_next   = m_sampled_reg;
        m_status_next    = m_status_reg;
        div_start        = 1'b0;
        rd_addr          = '0;
        wr_en            = 1'b0;
        wr_addr          = pos_reg;
        wr_data          = '{value: val_reg, stamp: stamp_reg};

        // drop the output beat once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    op_next          = s_operation;
                    val_next         = s_item_value;
                    issue_next       = '0;
                    hit_next         = 1'b0;
                    res_flag_next    = 1'b0;
                    res_sampled_next = '0;
                    res_status_next  = STATUS_OK;
                    case (s_operation)
                        OP_INSERT: begin
                            if (count_reg == CNT_W'(CAPACITY)) begin
                                res_status_next = STATUS_FULL;
                                state_next      = ST_DONE;
                            end else begin
                                state_next = ST_SCAN;
                            end
                        end
                        OP_REMOVE: begin
                            state_next = ST_SCAN;
                        end
                        OP_SAMPLE: begin
                            if (count_reg == '0) begin
                                res_status_next = STATUS_EMPTY;
                                state_next      = ST_DONE;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        default: begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_SCAN: begin
                // issue one slot read per cycle, compare it in the following cycle
                if (issue_reg != count_reg) begin
                    rd_addr       = issue_reg[IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                    pipe_vld_next = 1'b1;
                    pipe_idx_next = issue_reg[IDX_W-1:0];
                end
                if (pipe_vld_reg && slot_match) begin
                    hit_next  = 1'b1;
                    pos_next  = pipe_idx_reg;
                    best_next = rd_data.stamp;
                end
                if ((issue_reg == count_reg) && !pipe_vld_reg) begin
                    if (op_reg == OP_INSERT) begin
                        state_next = ST_INS_WR;
                    end else if (!hit_reg) begin
                        state_next = ST_DONE;
                    end else if (pos_reg == last_idx[IDX_W-1:0]) begin
                        // newest copy sits in the last slot: just shrink
                        count_next    = last_idx;
                        res_flag_next = 1'b1;
                        state_next    = ST_DONE;
                    end else begin
                        state_next = ST_RD_LAST;
                    end
                end
            end

            ST_INS_WR: begin
                wr_en         = 1'b1;
                wr_addr       = count_reg[IDX_W-1:0];
                stamp_next    = stamp_reg + 1'b1;
                count_next    = count_reg + 1'b1;
                res_flag_next = !hit_reg;
                state_next    = ST_DONE;
            end

            ST_RD_LAST: begin
                rd_addr    = last_idx[IDX_W-1:0];
                state_next = ST_RM_WR;
            end

            ST_RM_WR: begin
                // move the last slot's value into the hole with a fresh stamp
                wr_en         = 1'b1;
                wr_addr       = pos_reg;
                wr_data       = '{value: rd_data.value, stamp: stamp_reg};
                stamp_next    = stamp_reg + 1'b1;
                count_next    = last_idx;
                res_flag_next = 1'b1;
                state_next    = ST_DONE;
            end

            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_RD_SAMP;
                end
            end

            ST_RD_SAMP: begin
                rd_addr    = div_rem[IDX_W-1:0];
                state_next = ST_SAMP_GET;
            end

            ST_SAMP_GET: begin
                res_sampled_next = rd_data.value;
                state_next       = ST_DONE;
            end

            ST_DONE: begin
                // hold until the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next   = 1'b1;
                    m_flag_next    = res_flag_reg;
                    m_sampled_next = res_sampled_reg;
                    m_status_next  = res_status_reg;
                    state_next     = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            stamp_reg    <= '0;
            pipe_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            stamp_reg    <= stamp_next;
            pipe_vld_reg <= pipe_vld_next;
            m_valid_reg  <= m_valid_next;
        end
        op_reg          <= op_next;
        val_reg         <= val_next;
        issue_reg       <= issue_next;
        pipe_idx_reg    <= pipe_idx_next;
        hit_reg         <= hit_next;
        pos_reg         <= pos_next;
        best_reg        <= best_next;
        res_flag_reg    <= res_flag_next;
        res_sampled_reg <= res_sampled_next;
        res_status_reg  <= res_status_next;
        m_flag_reg      <= m_flag_next;
        m_sampled_reg   <= m_sampled_next;
        m_status_reg    <= m_status_next;
    end

    // slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            slot_mem[wr_addr] <= wr_data;
        end
        rd_data <= slot_mem[rd_addr];
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_flag          = m_flag_reg;
    assign m_sampled_value = m_sampled_reg;
    assign m_status        = m_status_reg;

endmodule

// ----- rtl/rsmt_checker.sv -----
// ----------------------------------------------------------------------------
// rsmt_checker
// Port-level checks for the random-sample multiset table, bound to the top.
// ----------------------------------------------------------------------------
module rsmt_checker
    import rsmt_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic [1:0]                s_operation,
    input logic signed [VALUE_W-1:0] s_item_value,
    input logic [RAND_W-1:0]         s_random_word,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic                      m_flag,
    input logic signed [VALUE_W-1:0] m_sampled_value,
    input logic [1:0]                m_status
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_flag) &&
        $stable(m_sampled_value) && $stable(m_status))
        else $error("output beat changed while stalled");

    // one item at a time: input side closes right after a beat
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // error beats carry no flag and no sample
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STATUS_FULL || m_status == STATUS_EMPTY) |->
        !m_flag && (m_sampled_value == '0))
        else $error("error beat with flag or sample");

    // flag belongs to insert or remove, which never sample
    a_flag_no_sample: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_flag |-> (m_sampled_value == '0) && (m_status == STATUS_OK))
        else $error("flagged beat with sample or error");

endmodule

bind random_sample_multiset_table_top rsmt_checker u_rsmt_checker (.*);

// ----- tb/random_sample_multiset_table_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_sample_multiset_table_top_tb
// Self-checking bench for the random-sample multiset table. A behavioral
// mirror of the slot table predicts every result beat at the moment its
// input beat is taken. A monitor compares each result beat with the oldest
// prediction. Directed checks cover empty-table and extreme values. Random
// traffic fills the table to capacity and drains it, under three idle
// patterns on the two channels.
// ----------------------------------------------------------------------------
module random_sample_multiset_table_top_tb;
    import rsmt_pkg::*;

    localparam int TABLE_DEPTH   = 64;
    localparam int CLK_PERIOD    = 8;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1000000;

    // the one operation code the package leaves unnamed; the block must ignore it
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic [RAND_W-1:0]         WORD_MAX = {RAND_W{1'b1}};

    typedef struct packed {
        logic                      flag;
        logic signed [VALUE_W-1:0] sampled_value;
        logic [1:0]                status;
    } outcome_t;

    // ------------------------------------------------------------------------
    // clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                      aclk            = 1'b0;
    logic                      aresetn         = 1'b0;
    logic                      s_valid         = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_operation     = OP_INSERT;
    logic signed [VALUE_W-1:0] s_item_value    = '0;
    logic [RAND_W-1:0]         s_random_word   = '0;
    logic                      m_valid;
    logic                      m_ready         = 1'b0;
    logic                      m_flag;
    logic signed [VALUE_W-1:0] m_sampled_value;
    logic [1:0]                m_status;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    random_sample_multiset_table_top #(
        .CAPACITY(TABLE_DEPTH)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_item_value   (s_item_value),
        .s_random_word  (s_random_word),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_flag         (m_flag),
        .m_sampled_value(m_sampled_value),
        .m_status       (m_status)
    );

    // ------------------------------------------------------------------------
    // mirror of the slot table; it advances only when an input beat is taken,
    // so it always reflects the order in which the block processes beats
    // ------------------------------------------------------------------------
    logic [VALUE_W-1:0] tbl_value [TABLE_DEPTH];
    logic [STAMP_W-1:0] tbl_stamp [TABLE_DEPTH];
    int unsigned        tbl_count  = 0;
    logic [STAMP_W-1:0] next_stamp = '0;

    outcome_t pending_results[$];

    int error_count   = 0;
    int cycle_count   = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // tallies for the closing summary
    int n_beats      = 0;
    int n_inserts    = 0;
    int n_refused    = 0;
    int n_removes    = 0;
    int n_remove_hit = 0;
    int n_samples    = 0;
    int n_empty      = 0;
    int n_unused     = 0;
    int peak_fill    = 0;

    logic signed [VALUE_W-1:0] value_pool [8];

    // Apply one operation to the mirror and return the result beat it must cause.
    function automatic outcome_t predict_table_op(input logic [1:0] op,
                                                  input logic [VALUE_W-1:0] val,
                                                  input logic [RAND_W-1:0] rnd);
        outcome_t           res;
        logic               hit;
        int unsigned        pos;
        int unsigned        last;
        logic [STAMP_W-1:0] newest;
        res    = '0;
        hit    = 1'b0;
        pos    = 0;
        newest = '0;
        n_beats++;
        case (op)
            OP_INSERT: begin
                n_inserts++;
                if (tbl_count >= TABLE_DEPTH) begin
                    res.status = STATUS_FULL;
                    n_refused++;
                end else begin
                    for (int i = 0; i < tbl_count; i++)
                        if (tbl_value[i] == val) hit = 1'b1;
                    tbl_value[tbl_count] = val;
                    tbl_stamp[tbl_count] = next_stamp;
                    next_stamp++;
                    tbl_count++;
                    res.flag = !hit;
                    if (tbl_count > peak_fill) peak_fill = tbl_count;
                end
            end
            OP_REMOVE: begin
                n_removes++;
                // newest copy wins; strict compare keeps the lowest slot on a tie
                for (int i = 0; i < tbl_count; i++) begin
                    if (tbl_value[i] == val && (!hit || tbl_stamp[i] > newest)) begin
                        hit    = 1'b1;
                        pos    = i;
                        newest = tbl_stamp[i];
                    end
                end
                if (hit) begin
                    last = tbl_count - 1;
                    if (pos != last) begin
                        tbl_value[pos] = tbl_value[last];
                        tbl_stamp[pos] = next_stamp;
                        next_stamp++;
                    end
                    tbl_count = last;
                    res.flag  = 1'b1;
                    n_remove_hit++;
                end
            end
            OP_SAMPLE: begin
                n_samples++;
                if (tbl_count == 0) begin
                    res.status = STATUS_EMPTY;
                    n_empty++;
                end else begin
                    res.sampled_value = tbl_value[rnd % tbl_count];
                end
            end
            default: begin
                n_unused++;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // input side: send one beat, honoring the sender idle rate. Valid stays
    // high after a taken beat so back-to-back beats need no second assignment
    // in the same step; drop it only for an idle gap or the final drain.
    // ------------------------------------------------------------------------
    task automatic send_beat(input logic [1:0] op,
                             input logic signed [VALUE_W-1:0] val,
                             input logic [RAND_W-1:0] rnd);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_item_value  <= val;
        s_random_word <= rnd;
        // hold the beat until the block takes it
        do @(posedge aclk); while (!s_ready);
        pending_results = {pending_results, predict_table_op(op, val, rnd)};
    endtask

    task automatic wait_drained(input int settle);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // value choice: a small pool makes duplicates common, present values make
    // removes hit, and fresh random words keep every bit toggling
    // ------------------------------------------------------------------------
    function automatic logic signed [VALUE_W-1:0] any_word();
        logic [31:0] r;
        r = $urandom;
        return r;
    endfunction

    function automatic logic signed [VALUE_W-1:0] extreme_value();
        case ($urandom_range(3))
            0:       return VAL_MIN;
            1:       return VAL_MAX;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    task automatic refresh_pool();
        foreach (value_pool[i])
            value_pool[i] = ($urandom_range(3) == 0) ? extreme_value() : any_word();
    endtask

    function automatic logic signed [VALUE_W-1:0] present_value();
        if (tbl_count == 0) return value_pool[$urandom_range(7)];
        return tbl_value[$urandom_range(tbl_count - 1)];
    endfunction

    function automatic logic signed [VALUE_W-1:0] choose_insert_value();
        int r;
        r = $urandom_range(99);
        if (r < 50) return value_pool[$urandom_range(7)];
        if (r < 85) return present_value();
        return any_word();
    endfunction

    function automatic logic signed [VALUE_W-1:0] choose_remove_value();
        int r;
        r = $urandom_range(99);
        if (r < 70) return present_value();
        if (r < 90) return value_pool[$urandom_range(7)];
        return any_word();
    endfunction

    function automatic logic [RAND_W-1:0] choose_sample_word();
        logic [31:0] r;
        int          pick;
        r    = $urandom;
        pick = $urandom_range(99);
        if (pick < 60) return r[RAND_W-1:0];
        if (pick < 85) return RAND_W'($urandom_range(tbl_count + 3));
        return (pick < 92) ? WORD_MAX : '0;
    endfunction

    // ------------------------------------------------------------------------
    // test tasks
    // ------------------------------------------------------------------------

    // Sample and remove on an empty table, and the unused code with extremes.
    task automatic test_empty_table();
        send_beat(OP_SAMPLE, any_word(), '0);
        send_beat(OP_REMOVE, 32'sd5, WORD_MAX);
        send_beat(OP_UNUSED, VAL_MIN, WORD_MAX);
        send_beat(OP_SAMPLE, VAL_MAX, WORD_MAX);
    endtask

    // Extreme values, duplicates, removal of the newest copy, removal of the
    // last slot, an absent value, and the unused code on a loaded table.
    task automatic test_value_extremes();
        send_beat(OP_INSERT, VAL_MIN, '0);
        send_beat(OP_INSERT, VAL_MAX, WORD_MAX);
        send_beat(OP_INSERT, 32'sd0, '0);
        send_beat(OP_INSERT, -32'sd1, '0);
        send_beat(OP_INSERT, VAL_MAX, '0);          // duplicate: absent flag low
        send_beat(OP_INSERT, VAL_MIN, '0);
        send_beat(OP_SAMPLE, 32'sd0, '0);
        send_beat(OP_SAMPLE, 32'sd0, WORD_MAX);
        send_beat(OP_SAMPLE, 32'sd0, 31'd5);
        send_beat(OP_REMOVE, VAL_MAX, '0);          // newest copy, last slot moves in
        send_beat(OP_REMOVE, VAL_MIN, '0);          // newest copy now sits in last slot
        send_beat(OP_REMOVE, 32'sd12345, '0);       // absent
        send_beat(OP_REMOVE, 32'sd0, '0);
        send_beat(OP_UNUSED, -32'sd1, 31'h5555_5555);
        send_beat(OP_INSERT, 32'sh5555_5555, 31'h2aaa_aaaa);
        send_beat(OP_INSERT, 32'shaaaa_aaaa, 31'h5555_5555);
        send_beat(OP_SAMPLE, 32'sd0, 31'd4);
        send_beat(OP_REMOVE, -32'sd1, '0);
        send_beat(OP_REMOVE, -32'sd1, '0);          // second copy does not exist
    endtask

    // Fill to capacity, push against the full table, then drain to empty.
    task automatic test_fill_to_capacity();
        refresh_pool();
        while (tbl_count < TABLE_DEPTH)
            send_beat(OP_INSERT, choose_insert_value(), choose_sample_word());
        send_beat(OP_INSERT, extreme_value(), WORD_MAX);
        send_beat(OP_INSERT, any_word(), '0);
        repeat (3) send_beat(OP_SAMPLE, any_word(), choose_sample_word());
        while (tbl_count > 0) begin
            if ($urandom_range(9) == 0)
                send_beat(OP_SAMPLE, any_word(), choose_sample_word());
            else
                send_beat(OP_REMOVE, choose_remove_value(), choose_sample_word());
        end
        send_beat(OP_SAMPLE, any_word(), choose_sample_word());
    endtask

    // Mixed traffic that swings between growing and shrinking the table, so
    // the fill level sweeps the whole range including full and empty.
    task automatic test_random_mix(input int beats);
        logic growing;
        int   run_left;
        int   r;
        logic [1:0] op;
        refresh_pool();
        growing  = $urandom_range(1);
        run_left = $urandom_range(20, 120);
        repeat (beats) begin
            if (run_left == 0) begin
                growing  = !growing;
                run_left = $urandom_range(20, 120);
            end
            run_left--;
            r = $urandom_range(99);
            if (r < (growing ? 70 : 20))      op = OP_INSERT;
            else if (r < (growing ? 82 : 75)) op = OP_REMOVE;
            else if (r < 97)                  op = OP_SAMPLE;
            else                              op = OP_UNUSED;
            case (op)
                OP_INSERT: send_beat(op, choose_insert_value(), choose_sample_word());
                OP_REMOVE: send_beat(op, choose_remove_value(), choose_sample_word());
                default:   send_beat(op, any_word(), choose_sample_word());
            endcase
        end
    endtask

    // ------------------------------------------------------------------------
    // result side: receiver stalls at the current rate, every beat is checked
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin : result_check
        outcome_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: flag %0b value %0d status %0d",
                       m_flag, m_sampled_value, m_status);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_flag !== want.flag) begin
                    $error("flag mismatch: expected %0b, actual %0b", want.flag, m_flag);
                    error_count++;
                end
                if (m_sampled_value !== want.sampled_value) begin
                    $error("sampled_value mismatch: expected %0d, actual %0d",
                           want.sampled_value, m_sampled_value);
                    error_count++;
                end
                if (m_status !== want.status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           want.status, m_status);
                    error_count++;
                end
            end
        end
    end

    // Guard against a hung block.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, pending_results.size());
            $display("random_sample_multiset_table_top test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // sequence: reset once, then the tests under three idle patterns
    // ------------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // phase one: sender idles rarely, receiver stalls most cycles
        send_idle_pct = 10;
        recv_idle_pct = 82;
        test_empty_table();
        test_value_extremes();
        test_fill_to_capacity();
        test_random_mix(480);

        // phase two: the other way round
        send_idle_pct = 82;
        recv_idle_pct = 10;
        test_random_mix(480);

        // phase three: both sides run flat out
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mix(480);

        wait_drained(SETTLE_CYCLES);

        $display("covered %0d beats: %0d inserts (%0d refused full), %0d removes (%0d hit),",
                 n_beats, n_inserts, n_refused, n_removes, n_remove_hit);
        $display("  %0d samples (%0d on empty), %0d unused-code beats, peak fill %0d of %0d",
                 n_samples, n_empty, n_unused, peak_fill, TABLE_DEPTH);
        if (error_count == 0)
            $display("random_sample_multiset_table_top test passed");
        else
            $display("random_sample_multiset_table_top test failed");
        $finish;
    end

endmodule
